// ===== hw/rtl/tqe_pkg.sv =====
// ----------------------------------------------------------------------------
// tqe_pkg
// Types and codes shared by the timeout queue engine modules.
// ----------------------------------------------------------------------------
package tqe_pkg;

    // command kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // result kinds
    localparam logic [1:0] RK_REG    = 2'd0;
    localparam logic [1:0] RK_CANCEL = 2'd1;
    localparam logic [1:0] RK_EXPIRY = 2'd2;
    localparam logic [1:0] RK_IDLE   = 2'd3;

    localparam int DL_W    = 48;
    localparam int ID_W    = 16;
    localparam int WAIT_W  = 32;
    localparam int CFG_W   = 16;
    localparam int MAX_OUT = 16;

    localparam logic [CFG_W-1:0] EMPTY_WAIT_RST = 16'd16000;
    localparam logic [ID_W-1:0]  FIRST_ID       = 16'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] delay_ms;
        logic [31:0] tag;
        logic [15:0] cancel_id;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] timer_id;
        logic [31:0] expired_tag;
        logic        found;
        logic        table_full;
        logic [31:0] ms_to_next;
        logic        last;
    } t_result;

    // operations on the entry table
    typedef struct packed {
        logic fill;
        logic drop;
        logic mark;
    } t_tbl_op;

    // scanner status
    typedef struct packed {
        logic done;
        logic best_valid;
        logic match_valid;
    } t_scan_stat;

endpackage

// ===== hw/rtl/tqe_table.sv =====
// ----------------------------------------------------------------------------
// tqe_table
// Entry memory (deadline, id, tag) with one registered read port and one
// write port, plus pending and cancelled flags and the free slot finder.
// ----------------------------------------------------------------------------
module tqe_table #(
    parameter int CAPACITY = 16,
    parameter int TAG_W    = 32,
    localparam int SLOT_W  = $clog2(CAPACITY)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [SLOT_W-1:0]        i_rd_addr,
    output logic [tqe_pkg::DL_W-1:0] o_rd_dl,
    output logic [tqe_pkg::ID_W-1:0] o_rd_id,
    output logic [TAG_W-1:0]         o_rd_tag,
    input  tqe_pkg::t_tbl_op         i_op,
    input  logic [SLOT_W-1:0]        i_op_slot,
    input  logic [tqe_pkg::DL_W-1:0] i_wr_dl,
    input  logic [tqe_pkg::ID_W-1:0] i_wr_id,
    input  logic [TAG_W-1:0]         i_wr_tag,
    output logic [CAPACITY-1:0]      o_valid,
    output logic [CAPACITY-1:0]      o_cancelled,
    output logic                     o_full
);

    localparam int ENT_W = tqe_pkg::DL_W + tqe_pkg::ID_W + TAG_W;

    logic [ENT_W-1:0]    r_mem [CAPACITY];
    logic [ENT_W-1:0]    r_rd;
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] r_cancelled;
    logic [SLOT_W-1:0]   free_slot;
    logic                any_free;
    logic                do_fill;

    // lowest free slot
    always_comb begin
        free_slot = '0;
        any_free  = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SLOT_W'(i);
                any_free  = 1'b1;
            end
        end
    end

    assign do_fill = i_op.fill && any_free;

    always_ff @(posedge i_clk) begin
        if (do_fill) begin
            r_mem[free_slot] <= {i_wr_dl, i_wr_id, i_wr_tag};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cancelled <= '0;
        end else begin
            if (do_fill) begin
                r_valid[free_slot]     <= 1'b1;
                r_cancelled[free_slot] <= 1'b0;
            end
            if (i_op.drop) begin
                r_valid[i_op_slot]     <= 1'b0;
                r_cancelled[i_op_slot] <= 1'b0;
            end
            if (i_op.mark) begin
                r_cancelled[i_op_slot] <= 1'b1;
            end
        end
    end

    assign o_rd_dl     = r_rd[ENT_W-1 -: tqe_pkg::DL_W];
    assign o_rd_id     = r_rd[TAG_W +: tqe_pkg::ID_W];
    assign o_rd_tag    = r_rd[TAG_W-1:0];
    assign o_valid     = r_valid;
    assign o_cancelled = r_cancelled;
    assign o_full      = !any_free;

endmodule

// ===== hw/rtl/tqe_scan.sv =====
// ----------------------------------------------------------------------------
// tqe_scan
// Walks the entry memory one slot per cycle, keeping the earliest pending
// deadline (lowest slot on ties) and the lowest pending slot with a given id.
// ----------------------------------------------------------------------------
module tqe_scan #(
    parameter int CAPACITY = 16,
    localparam int SLOT_W  = $clog2(CAPACITY)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CAPACITY-1:0]      i_valid,
    input  logic [tqe_pkg::DL_W-1:0] i_rd_dl,
    input  logic [tqe_pkg::ID_W-1:0] i_rd_id,
    input  logic [tqe_pkg::ID_W-1:0] i_cid,
    output logic [SLOT_W-1:0]        o_rd_addr,
    output tqe_pkg::t_scan_stat      o_stat,
    output logic [SLOT_W-1:0]        o_best_slot,
    output logic [tqe_pkg::DL_W-1:0] o_best_dl,
    output logic [SLOT_W-1:0]        o_match_slot
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

    logic                     r_busy;
    logic [SLOT_W-1:0]        r_addr;
    logic                     r_chk;
    logic [SLOT_W-1:0]        r_chk_slot;
    logic                     r_chk_last;
    logic                     r_done;
    logic                     r_best_v;
    logic [SLOT_W-1:0]        r_best_slot;
    logic [tqe_pkg::DL_W-1:0] r_best_dl;
    logic                     r_match_v;
    logic [SLOT_W-1:0]        r_match_slot;
    logic                     entry_v;
    logic                     take_best;
    logic                     take_match;

    // read data lines up with r_chk_slot
    assign entry_v    = r_chk && i_valid[r_chk_slot];
    assign take_best  = entry_v && (!r_best_v || (i_rd_dl < r_best_dl));
    assign take_match = entry_v && !r_match_v && (i_rd_id == i_cid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_chk     <= 1'b0;
            r_done    <= 1'b0;
            r_best_v  <= 1'b0;
            r_match_v <= 1'b0;
        end else begin
            r_chk  <= r_busy;
            r_done <= r_chk && r_chk_last;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_best_v  <= 1'b0;
                r_match_v <= 1'b0;
            end else begin
                if (r_busy && (r_addr == LAST_SLOT)) begin
                    r_busy <= 1'b0;
                end
                if (take_best) begin
                    r_best_v <= 1'b1;
                end
                if (take_match) begin
                    r_match_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr <= '0;
        end else if (r_busy && (r_addr != LAST_SLOT)) begin
            r_addr <= r_addr + SLOT_W'(1);
        end
        r_chk_slot <= r_addr;
        r_chk_last <= r_busy && (r_addr == LAST_SLOT);
        if (take_best) begin
            r_best_slot <= r_chk_slot;
            r_best_dl   <= i_rd_dl;
        end
        if (take_match) begin
            r_match_slot <= r_chk_slot;
        end
    end

    assign o_rd_addr          = r_addr;
    assign o_stat.done        = r_done;
    assign o_stat.best_valid  = r_best_v;
    assign o_stat.match_valid = r_match_v;
    assign o_best_slot        = r_best_slot;
    assign o_best_dl          = r_best_dl;
    assign o_match_slot       = r_match_slot;

endmodule

// ===== hw/rtl/timeout_queue_engine_top.sv =====
// ----------------------------------------------------------------------------
// timeout_queue_engine_top
// Table of pending timeouts with a millisecond tick, registration, cancel
// and expiry reporting.
//
//  channel   ports                     direction  transfer
//  command   start, busy, i_cmd        in         start high while busy low
//  result    o_strobe, o_result        out        o_strobe high, one cycle
//  config    i_cfg_we, i_cfg_wdata     in         i_cfg_we high
//
// Every known command costs one or more full scans of the entry memory, one
// slot per cycle through its single read port. A tick removes r entries
// and reports e of them (e at most 16), results on consecutive cycles at
// the end. Reset (synchronous, low) clears flags, clock and id counter.
// Results cannot be held off; busy drops in the cycle that carries the last
// result, so the next command can be taken at the edge that takes it.
// ----------------------------------------------------------------------------
module timeout_queue_engine_top #(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tqe_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_we,
    input  logic [tqe_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                      o_strobe,
    output tqe_pkg::t_result          o_result
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int TAG_W  = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int IDX_W  = $clog2(tqe_pkg::MAX_OUT);
    localparam int CNT_W  = $clog2(tqe_pkg::MAX_OUT + 1);
    localparam int DL_W   = tqe_pkg::DL_W;
    localparam int ID_W   = tqe_pkg::ID_W;
    localparam int WAIT_W = tqe_pkg::WAIT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ONE  = 3'd4;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [1:0]                r_kind;
    logic [ID_W-1:0]           r_cid;
    logic [DL_W-1:0]           r_now;
    logic [ID_W-1:0]           r_next_id;
    logic [ID_W-1:0]           r_res_id;
    logic                      r_res_full;
    logic [tqe_pkg::CFG_W-1:0] r_empty_wait;
    logic [CNT_W-1:0]          r_n;
    logic [CNT_W-1:0]          r_ei;
    logic [SLOT_W-1:0]         r_list [tqe_pkg::MAX_OUT];
    logic [WAIT_W-1:0]         r_wait;
    logic                      r_strobe;
    tqe_pkg::t_result          r_out;

    logic                accept;
    logic                cmd_known;
    logic [DL_W:0]       dl_sum;
    logic [DL_W-1:0]     wr_dl;
    logic [ID_W-1:0]     id_inc;
    logic [DL_W-1:0]     diff;
    logic [WAIT_W-1:0]   wait_calc;
    logic                expired;
    logic                best_cancelled;
    logic                removing;
    logic                scan_start;
    logic [SLOT_W-1:0]   rd_addr;
    logic [SLOT_W-1:0]   op_slot;

    tqe_pkg::t_tbl_op    tbl_op;
    tqe_pkg::t_scan_stat scan_stat;
    logic [DL_W-1:0]     rd_dl;
    logic [ID_W-1:0]     rd_id;
    logic [TAG_W-1:0]    rd_tag;
    logic [CAPACITY-1:0] tbl_valid;
    logic [CAPACITY-1:0] tbl_cancelled;
    logic                tbl_full;
    logic [SLOT_W-1:0]   scan_addr;
    logic [SLOT_W-1:0]   best_slot;
    logic [DL_W-1:0]     best_dl;
    logic [SLOT_W-1:0]   match_slot;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign cmd_known = (i_cmd.kind == tqe_pkg::KIND_TICK) ||
                       (i_cmd.kind == tqe_pkg::KIND_REG) ||
                       (i_cmd.kind == tqe_pkg::KIND_CANCEL);

    // deadline saturates at the top of the 48-bit range
    assign dl_sum = {1'b0, r_now} + (DL_W + 1)'(i_cmd.delay_ms);
    assign wr_dl  = dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];

    always_comb begin
        id_inc = r_next_id + ID_W'(1);
        if (id_inc == '0) begin
            id_inc = tqe_pkg::FIRST_ID;
        end
    end

    assign best_cancelled = tbl_cancelled[best_slot];
    assign expired        = scan_stat.best_valid && (best_dl <= r_now);
    // cancelled entries go even when the report limit is reached
    assign removing = (r_state == S_SCAN) && scan_stat.done &&
                      (r_kind == tqe_pkg::KIND_TICK) && expired &&
                      (best_cancelled || (r_n < CNT_W'(tqe_pkg::MAX_OUT)));
    assign scan_start = (accept && cmd_known) || removing;

    assign tbl_op.fill = accept && (i_cmd.kind == tqe_pkg::KIND_REG) && !tbl_full;
    assign tbl_op.drop = removing;
    assign tbl_op.mark = (r_state == S_SCAN) && scan_stat.done &&
                         (r_kind == tqe_pkg::KIND_CANCEL) && scan_stat.match_valid;
    assign op_slot     = tbl_op.mark ? match_slot : best_slot;

    assign rd_addr = (r_state == S_SCAN) ? scan_addr : r_list[r_ei[IDX_W-1:0]];

    always_comb begin
        diff = best_dl - r_now;
        if (!scan_stat.best_valid) begin
            wait_calc = WAIT_W'(r_empty_wait);
        end else if (best_dl <= r_now) begin
            wait_calc = '0;
        end else if (|diff[DL_W-1:WAIT_W]) begin
            wait_calc = '1;
        end else begin
            wait_calc = diff[WAIT_W-1:0];
        end
    end

    tqe_table #(
        .CAPACITY (CAPACITY),
        .TAG_W    (TAG_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (rd_addr),
        .o_rd_dl     (rd_dl),
        .o_rd_id     (rd_id),
        .o_rd_tag    (rd_tag),
        .i_op        (tbl_op),
        .i_op_slot   (op_slot),
        .i_wr_dl     (wr_dl),
        .i_wr_id     (r_next_id),
        .i_wr_tag    (TAG_W'(i_cmd.tag)),
        .o_valid     (tbl_valid),
        .o_cancelled (tbl_cancelled),
        .o_full      (tbl_full)
    );

    tqe_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (scan_start),
        .i_valid      (tbl_valid),
        .i_rd_dl      (rd_dl),
        .i_rd_id      (rd_id),
        .i_cid        (r_cid),
        .o_rd_addr    (scan_addr),
        .o_stat       (scan_stat),
        .o_best_slot  (best_slot),
        .o_best_dl    (best_dl),
        .o_match_slot (match_slot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && cmd_known) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_stat.done && !removing) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if ((r_kind == tqe_pkg::KIND_TICK) && (r_n != '0)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ONE;
                end
            end
            S_EMIT: begin
                if (r_ei == r_n) begin
                    n_state = S_IDLE;
                end
            end
            S_ONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_next_id    <= tqe_pkg::FIRST_ID;
            r_empty_wait <= tqe_pkg::EMPTY_WAIT_RST;
            r_n          <= '0;
            r_ei         <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_empty_wait <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_n  <= '0;
                        r_ei <= '0;
                        if (i_cmd.kind == tqe_pkg::KIND_TICK) begin
                            r_now <= r_now + DL_W'(1);
                        end
                        if (tbl_op.fill) begin
                            r_next_id <= id_inc;
                        end
                    end
                end
                S_SCAN: begin
                    if (removing && !best_cancelled) begin
                        r_n <= r_n + CNT_W'(1);
                    end
                end
                S_WAIT: begin
                    r_ei <= CNT_W'(1);
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_ei != r_n) begin
                        r_ei <= r_ei + CNT_W'(1);
                    end
                end
                S_ONE: begin
                    r_strobe <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && accept) begin
            r_kind     <= i_cmd.kind;
            r_cid      <= i_cmd.cancel_id;
            r_res_id   <= tbl_op.fill ? r_next_id : '0;
            r_res_full <= tbl_full;
        end
        if (removing && !best_cancelled) begin
            r_list[r_n[IDX_W-1:0]] <= best_slot;
        end
        if (r_state == S_WAIT) begin
            r_wait <= wait_calc;
        end
        if (r_state == S_EMIT) begin
            // memory data belongs to the list entry issued last cycle
            r_out.result_kind <= tqe_pkg::RK_EXPIRY;
            r_out.timer_id    <= rd_id;
            r_out.expired_tag <= 32'(rd_tag);
            r_out.found       <= 1'b0;
            r_out.table_full  <= 1'b0;
            r_out.ms_to_next  <= r_wait;
            r_out.last        <= (r_ei == r_n);
        end
        if (r_state == S_ONE) begin
            r_out.expired_tag <= '0;
            r_out.ms_to_next  <= r_wait;
            r_out.last        <= 1'b1;
            unique case (r_kind)
                tqe_pkg::KIND_REG: begin
                    r_out.result_kind <= tqe_pkg::RK_REG;
                    r_out.timer_id    <= r_res_id;
                    r_out.found       <= 1'b0;
                    r_out.table_full  <= r_res_full;
                end
                tqe_pkg::KIND_CANCEL: begin
                    r_out.result_kind <= tqe_pkg::RK_CANCEL;
                    r_out.timer_id    <= r_cid;
                    r_out.found       <= scan_stat.match_valid;
                    r_out.table_full  <= 1'b0;
                end
                default: begin
                    r_out.result_kind <= tqe_pkg::RK_IDLE;
                    r_out.timer_id    <= '0;
                    r_out.found       <= 1'b0;
                    r_out.table_full  <= 1'b0;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // final transfer of a command always lands back in idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.last) |-> (r_state == S_IDLE))
        else $error("last result without return to idle");

    a_more_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_out.last) |-> (r_state == S_EMIT))
        else $error("non-final result outside expiry burst");

    a_drop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_op.drop |-> tbl_valid[best_slot])
        else $error("removal of an entry that is not pending");

    a_report_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_n <= CNT_W'(tqe_pkg::MAX_OUT)))
        else $error("expiry list overflow");

endmodule
